>>> rtl/lirs_pkg.sv
// shared types, constants and codes of the linear interpolation resampler
`default_nettype none

package lirs_pkg;

  // fixed field widths
  localparam int RATE_W   = 18;
  localparam int SAMPLE_W = 16;

  // defaults of the top level parameters
  localparam int COUNT_WIDTH_DEF  = 32;
  localparam int MAX_UPSAMPLE_DEF = 16;

  // longest run of outputs one input word may cause
  localparam int MAX_RUN = 32;
  localparam int RUN_W   = $clog2(MAX_RUN + 1);

  // divider dividend width: biased interpolation numerator is below 2^34
  localparam int DIV_W   = 34;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  // configuration register reset values
  localparam logic [RATE_W-1:0] SRC_RATE_RST = 18'd44100;
  localparam logic [RATE_W-1:0] DST_RATE_RST = 18'd16000;

  // configuration register index
  typedef enum logic {
    REG_SRC_RATE = 1'b0,
    REG_DST_RATE = 1'b1
  } reg_idx_t;

  // input word
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       final_in;
  } in_word_t;

  // result word
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       valid_res;
    logic                       run_end;
    logic                       stream_end;
    logic                       ratio_error;
  } out_word_t;

  // divider operand select
  typedef enum logic [1:0] {
    DIV_STEP   = 2'd0,
    DIV_FOLD   = 2'd1,
    DIV_INTERP = 2'd2
  } div_sel_t;

  // kind of result word to launch
  typedef enum logic [1:0] {
    EMIT_NONE   = 2'd0,
    EMIT_SAMPLE = 2'd1,
    EMIT_ERROR  = 2'd2,
    EMIT_EMPTY  = 2'd3
  } emit_kind_t;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_ERR,
    ST_STEP_DIV,
    ST_FOLD_CHK,
    ST_FOLD_DIV,
    ST_SCAN,
    ST_MUL_A,
    ST_MUL_B,
    ST_QUOT_GO,
    ST_QUOT_DIV,
    ST_ADV,
    ST_EMIT,
    ST_EMPTY,
    ST_DONE
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic       load_in;
    logic       div_start;
    div_sel_t   div_sel;
    logic       step_latch;
    logic       fold_latch;
    logic       mul_first;
    logic       mul_second;
    logic       val_interp;
    logic       val_final;
    logic       advance;
    emit_kind_t emit;
    logic       commit;
    logic       commit_err;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic ratio_bad;
    logic div_done;
    logic rem_ge_dst;
    logic hit_interp;
    logic hit_final;
    logic run_empty;
    logic fin;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

>>> rtl/lirs_div.sv
// restoring divider, one quotient bit per cycle
`default_nettype none

module lirs_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [lirs_pkg::DIV_W-1:0]  dividend,
  input  wire logic [lirs_pkg::RATE_W-1:0] divisor,
  output logic                             done,
  output logic [lirs_pkg::DIV_W-1:0]       quotient,
  output logic [lirs_pkg::RATE_W-1:0]      remainder
);

  logic                              busy;
  logic [lirs_pkg::DIV_CNT_W-1:0]    cnt;
  logic [lirs_pkg::RATE_W-1:0]       dvs;
  logic [lirs_pkg::RATE_W:0]         rem_sh;
  logic                              ge;
  logic [lirs_pkg::RATE_W:0]         rem_sub;

  // one shift and trial subtract
  always_comb begin
    rem_sh  = {remainder, quotient[lirs_pkg::DIV_W-1]};
    ge      = rem_sh >= {1'b0, dvs};
    rem_sub = rem_sh - {1'b0, dvs};
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == lirs_pkg::DIV_CNT_W'(lirs_pkg::DIV_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  // operands and partial results
  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
      dvs       <= divisor;
    end else if (busy) begin
      quotient  <= {quotient[lirs_pkg::DIV_W-2:0], ge};
      remainder <= ge ? rem_sub[lirs_pkg::RATE_W-1:0] : rem_sh[lirs_pkg::RATE_W-1:0];
    end
  end

  // no restart while a division runs
  a_no_restart: assert property (@(posedge clk) disable iff (rst) !(start && busy))
    else $error("divider started while busy");

endmodule

`default_nettype wire

>>> rtl/lirs_datapath.sv
// stream state, position arithmetic, interpolation and result register
`default_nettype none

module lirs_datapath #(
  parameter int COUNT_WIDTH  = lirs_pkg::COUNT_WIDTH_DEF,
  parameter int MAX_UPSAMPLE = lirs_pkg::MAX_UPSAMPLE_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire lirs_pkg::dp_cmd_t           cmd,
  output lirs_pkg::dp_status_t             status,
  input  wire logic [lirs_pkg::RATE_W-1:0] src_rate,
  input  wire logic [lirs_pkg::RATE_W-1:0] dst_rate,
  input  wire lirs_pkg::in_word_t          src_word,
  output logic                             res_valid,
  input  wire logic                        res_ready,
  output lirs_pkg::out_word_t              res_word
);

  localparam int CW  = COUNT_WIDTH;
  localparam int RW  = lirs_pkg::RATE_W;
  localparam int DW  = lirs_pkg::DIV_W;
  localparam int UPW = $clog2(MAX_UPSAMPLE + 1);
  localparam int SW  = (CW > DW) ? CW : DW;

  // current word and stream state
  logic [lirs_pkg::SAMPLE_W-1:0] smp;
  logic                          fin;
  logic [lirs_pkg::SAMPLE_W-1:0] prev;
  logic                          have_prev;
  logic [CW-1:0]                 count;
  logic [CW-1:0]                 whole;
  logic [RW-1:0]                 prem;
  logic [RW-1:0]                 step_whole;
  logic [RW-1:0]                 step_rem;
  logic [DW-1:0]                 acc;
  logic [lirs_pkg::SAMPLE_W-1:0] val;
  logic [lirs_pkg::RUN_W-1:0]    run_n;

  // divider
  logic [DW-1:0] div_dividend;
  logic          div_done;
  logic [DW-1:0] div_q;
  logic [RW-1:0] div_r;

  logic [RW+UPW-1:0]             up_lim;
  logic                          ratio_bad;
  logic [lirs_pkg::SAMPLE_W-1:0] mul_x;
  logic [RW-1:0]                 mul_y;
  logic [DW-1:0]                 prod;
  logic [RW:0]                   rem_sum;
  logic                          rem_wrap;
  logic [CW-1:0]                 whole_adv;
  logic [RW-1:0]                 prem_adv;
  logic [SW-1:0]                 fold_sum;
  logic                          run_more;
  logic                          out_free;
  lirs_pkg::out_word_t           word_next;

  // rate pair check
  always_comb begin
    up_lim    = {{UPW{1'b0}}, src_rate} * (RW+UPW)'(MAX_UPSAMPLE);
    ratio_bad = (src_rate == '0) || (dst_rate == '0) || ({{UPW{1'b0}}, dst_rate} > up_lim);
  end

  // divider operand select
  always_comb begin
    case (cmd.div_sel)
      lirs_pkg::DIV_STEP:   div_dividend = DW'(src_rate);
      lirs_pkg::DIV_FOLD:   div_dividend = DW'(prem);
      lirs_pkg::DIV_INTERP: div_dividend = acc;
      default:              div_dividend = '0;
    endcase
  end

  lirs_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (div_dividend),
    .divisor   (dst_rate),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  // shared multiplier, samples biased to unsigned so the quotient floors
  always_comb begin
    if (cmd.mul_second) begin
      mul_x = {~smp[lirs_pkg::SAMPLE_W-1], smp[lirs_pkg::SAMPLE_W-2:0]};
      mul_y = prem;
    end else begin
      mul_x = {~prev[lirs_pkg::SAMPLE_W-1], prev[lirs_pkg::SAMPLE_W-2:0]};
      mul_y = dst_rate - prem;
    end
    prod = DW'(mul_x) * DW'(mul_y);
  end

  // position step and remainder fold
  always_comb begin
    rem_sum   = {1'b0, prem} + {1'b0, step_rem};
    rem_wrap  = rem_sum >= {1'b0, dst_rate};
    whole_adv = whole + CW'(step_whole) + CW'(rem_wrap);
    prem_adv  = rem_wrap ? RW'(rem_sum - {1'b0, dst_rate}) : rem_sum[RW-1:0];
    fold_sum  = SW'(whole) + SW'(div_q);
  end

  // run conditions
  always_comb begin
    status.ratio_bad  = ratio_bad;
    status.div_done   = div_done;
    status.rem_ge_dst = prem >= dst_rate;
    status.hit_interp = have_prev && (run_n < lirs_pkg::RUN_W'(lirs_pkg::MAX_RUN)) &&
                        (whole == count - CW'(1));
    status.hit_final  = fin && (run_n < lirs_pkg::RUN_W'(lirs_pkg::MAX_RUN)) &&
                        (whole == count);
    status.run_empty  = run_n == '0;
    status.fin        = fin;
    status.out_free   = out_free;
    run_more          = status.hit_interp || status.hit_final;
  end

  // word register
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      smp <= src_word.sample_in;
      fin <= src_word.final_in;
    end
  end

  // stream state
  always_ff @(posedge clk) begin
    if (rst) begin
      prev      <= '0;
      have_prev <= 1'b0;
      count     <= '0;
      whole     <= '0;
      prem      <= '0;
    end else if ((cmd.commit || cmd.commit_err) && fin) begin
      prev      <= '0;
      have_prev <= 1'b0;
      count     <= '0;
      whole     <= '0;
      prem      <= '0;
    end else if (cmd.commit) begin
      prev      <= smp;
      have_prev <= 1'b1;
      count     <= count + CW'(1);
    end else if (cmd.fold_latch) begin
      whole <= fold_sum[CW-1:0];
      prem  <= div_r;
    end else if (cmd.advance) begin
      whole <= whole_adv;
      prem  <= prem_adv;
    end
  end

  // step size, product accumulator, result value
  always_ff @(posedge clk) begin
    if (cmd.step_latch) begin
      step_whole <= div_q[RW-1:0];
      step_rem   <= div_r;
    end
    if (cmd.mul_first) begin
      acc <= prod;
    end else if (cmd.mul_second) begin
      acc <= acc + prod;
    end
    if (cmd.val_interp) begin
      val <= {~div_q[lirs_pkg::SAMPLE_W-1], div_q[lirs_pkg::SAMPLE_W-2:0]};
    end else if (cmd.val_final) begin
      val <= smp;
    end
  end

  // run counter
  always_ff @(posedge clk) begin
    if (rst || cmd.load_in) begin
      run_n <= '0;
    end else if (cmd.advance) begin
      run_n <= run_n + 1'b1;
    end
  end

  // result word
  always_comb begin
    word_next = '0;
    case (cmd.emit)
      lirs_pkg::EMIT_SAMPLE: begin
        word_next.sample_out = val;
        word_next.valid_res  = 1'b1;
        word_next.run_end    = !run_more;
        word_next.stream_end = !run_more && fin;
      end
      lirs_pkg::EMIT_ERROR: begin
        word_next.sample_out  = smp;
        word_next.valid_res   = 1'b1;
        word_next.run_end     = 1'b1;
        word_next.stream_end  = fin;
        word_next.ratio_error = 1'b1;
      end
      lirs_pkg::EMIT_EMPTY: begin
        word_next.run_end    = 1'b1;
        word_next.stream_end = 1'b1;
      end
      default: word_next = '0;
    endcase
  end

  // output register
  assign out_free = !res_valid || res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.emit != lirs_pkg::EMIT_NONE) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit != lirs_pkg::EMIT_NONE) begin
      res_word <= word_next;
    end
  end

  // a word is launched only into a free output slot
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit != lirs_pkg::EMIT_NONE) |-> out_free)
    else $error("result word launched over a pending one");

  // run length stays within bound
  a_run_bound: assert property (@(posedge clk) disable iff (rst)
    run_n <= lirs_pkg::RUN_W'(lirs_pkg::MAX_RUN))
    else $error("run counter out of range");

  // stream end always closes a run
  a_stream_end: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_word.stream_end) |-> res_word.run_end)
    else $error("stream end without run end");

  // an empty result only ever closes a stream
  a_empty_end: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_word.valid_res) |-> (res_word.stream_end && !res_word.ratio_error))
    else $error("empty result outside stream end");

endmodule

`default_nettype wire

>>> rtl/lirs_ctrl.sv
// sequencing state machine of the resampler
`default_nettype none

module lirs_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 src_valid,
  output logic                      src_ready,
  input  wire lirs_pkg::dp_status_t status,
  output lirs_pkg::dp_cmd_t         cmd
);

  lirs_pkg::state_t state;
  lirs_pkg::state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lirs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      lirs_pkg::ST_IDLE: begin
        if (src_valid) state_next = lirs_pkg::ST_CHECK;
      end
      lirs_pkg::ST_CHECK: begin
        state_next = status.ratio_bad ? lirs_pkg::ST_ERR : lirs_pkg::ST_STEP_DIV;
      end
      lirs_pkg::ST_ERR: begin
        if (status.out_free) state_next = lirs_pkg::ST_IDLE;
      end
      lirs_pkg::ST_STEP_DIV: begin
        if (status.div_done) state_next = lirs_pkg::ST_FOLD_CHK;
      end
      lirs_pkg::ST_FOLD_CHK: begin
        state_next = status.rem_ge_dst ? lirs_pkg::ST_FOLD_DIV : lirs_pkg::ST_SCAN;
      end
      lirs_pkg::ST_FOLD_DIV: begin
        if (status.div_done) state_next = lirs_pkg::ST_SCAN;
      end
      lirs_pkg::ST_SCAN: begin
        if (status.hit_interp) begin
          state_next = lirs_pkg::ST_MUL_A;
        end else if (status.hit_final) begin
          state_next = lirs_pkg::ST_ADV;
        end else if (status.fin && status.run_empty) begin
          state_next = lirs_pkg::ST_EMPTY;
        end else begin
          state_next = lirs_pkg::ST_DONE;
        end
      end
      lirs_pkg::ST_MUL_A:    state_next = lirs_pkg::ST_MUL_B;
      lirs_pkg::ST_MUL_B:    state_next = lirs_pkg::ST_QUOT_GO;
      lirs_pkg::ST_QUOT_GO:  state_next = lirs_pkg::ST_QUOT_DIV;
      lirs_pkg::ST_QUOT_DIV: begin
        if (status.div_done) state_next = lirs_pkg::ST_ADV;
      end
      lirs_pkg::ST_ADV:      state_next = lirs_pkg::ST_EMIT;
      lirs_pkg::ST_EMIT: begin
        if (status.out_free) state_next = lirs_pkg::ST_SCAN;
      end
      lirs_pkg::ST_EMPTY: begin
        if (status.out_free) state_next = lirs_pkg::ST_DONE;
      end
      lirs_pkg::ST_DONE:     state_next = lirs_pkg::ST_IDLE;
      default:               state_next = lirs_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd       = '0;
    cmd.div_sel = lirs_pkg::DIV_STEP;
    cmd.emit    = lirs_pkg::EMIT_NONE;
    src_ready = 1'b0;
    case (state)
      lirs_pkg::ST_IDLE: begin
        src_ready   = 1'b1;
        cmd.load_in = src_valid;
      end
      lirs_pkg::ST_CHECK: begin
        cmd.div_start = !status.ratio_bad;
        cmd.div_sel   = lirs_pkg::DIV_STEP;
      end
      lirs_pkg::ST_ERR: begin
        if (status.out_free) begin
          cmd.emit       = lirs_pkg::EMIT_ERROR;
          cmd.commit_err = 1'b1;
        end
      end
      lirs_pkg::ST_STEP_DIV: begin
        cmd.step_latch = status.div_done;
      end
      lirs_pkg::ST_FOLD_CHK: begin
        cmd.div_start = status.rem_ge_dst;
        cmd.div_sel   = lirs_pkg::DIV_FOLD;
      end
      lirs_pkg::ST_FOLD_DIV: begin
        cmd.fold_latch = status.div_done;
      end
      lirs_pkg::ST_SCAN: begin
        cmd.val_final = !status.hit_interp && status.hit_final;
      end
      lirs_pkg::ST_MUL_A: begin
        cmd.mul_first = 1'b1;
      end
      lirs_pkg::ST_MUL_B: begin
        cmd.mul_second = 1'b1;
      end
      lirs_pkg::ST_QUOT_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = lirs_pkg::DIV_INTERP;
      end
      lirs_pkg::ST_QUOT_DIV: begin
        cmd.val_interp = status.div_done;
      end
      lirs_pkg::ST_ADV: begin
        cmd.advance = 1'b1;
      end
      lirs_pkg::ST_EMIT: begin
        if (status.out_free) cmd.emit = lirs_pkg::EMIT_SAMPLE;
      end
      lirs_pkg::ST_EMPTY: begin
        if (status.out_free) cmd.emit = lirs_pkg::EMIT_EMPTY;
      end
      lirs_pkg::ST_DONE: begin
        cmd.commit = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/linear_interp_resampler_core.sv
// top level: configuration registers, controller and datapath of the resampler
//
// Linear interpolation sample rate converter for one 16-bit channel. Each input word
// takes one source sample and returns zero or more result words; an output sample at
// fractional source position w + r/dst_rate is floor((x[w]*(dst-r) + x[w+1]*r)/dst).
// Work per input word is done by one shared restoring divider and one shared multiplier:
// a division derives the position step, another folds the remainder if a rate change
// left it out of range, then every interpolated output takes two multiplies and a
// division and every repeated final sample a position advance, plus the wait for the
// consumer on each result word. The user must write configuration over the APB port
// only while no input word is in progress; the block itself does not enforce it. One
// result word can wait in the output register while the next input word is taken.
`default_nettype none

module linear_interp_resampler_core #(
  parameter int COUNT_WIDTH  = lirs_pkg::COUNT_WIDTH_DEF,
  parameter int MAX_UPSAMPLE = lirs_pkg::MAX_UPSAMPLE_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // configuration port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  // source words
  input  wire logic               src_valid,
  output logic                    src_ready,
  input  wire lirs_pkg::in_word_t src_word,
  // result words
  output logic                    res_valid,
  input  wire logic               res_ready,
  output lirs_pkg::out_word_t     res_word
);

  logic [lirs_pkg::RATE_W-1:0] src_rate;
  logic [lirs_pkg::RATE_W-1:0] dst_rate;
  lirs_pkg::reg_idx_t          reg_idx;
  lirs_pkg::dp_cmd_t           cmd;
  lirs_pkg::dp_status_t        status;

  assign reg_idx = lirs_pkg::reg_idx_t'(paddr[2]);
  assign pready  = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      src_rate <= lirs_pkg::SRC_RATE_RST;
      dst_rate <= lirs_pkg::DST_RATE_RST;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        lirs_pkg::REG_SRC_RATE: src_rate <= pwdata[lirs_pkg::RATE_W-1:0];
        lirs_pkg::REG_DST_RATE: dst_rate <= pwdata[lirs_pkg::RATE_W-1:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (reg_idx)
      lirs_pkg::REG_SRC_RATE: prdata = 32'(src_rate);
      lirs_pkg::REG_DST_RATE: prdata = 32'(dst_rate);
      default:                prdata = '0;
    endcase
  end

  lirs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_ready (src_ready),
    .status    (status),
    .cmd       (cmd)
  );

  lirs_datapath #(
    .COUNT_WIDTH  (COUNT_WIDTH),
    .MAX_UPSAMPLE (MAX_UPSAMPLE)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .src_rate  (src_rate),
    .dst_rate  (dst_rate),
    .src_word  (src_word),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_word  (res_word)
  );

endmodule

`default_nettype wire

>>> bench/testbench.sv
// self-checking bench for the linear interpolation resampler: directed table, then random streams
`timescale 1ns / 100ps

module testbench;
  import lirs_pkg::*;

  localparam int MAX_UP     = MAX_UPSAMPLE_DEF;
  localparam int RAND_ITEMS = 446;
  localparam int CALM_ITEMS = 40;
  localparam int SETTLE_CYC = 300;
  localparam int LIMIT      = 5000000;

  typedef enum logic {ROW_CFG, ROW_WORD} row_kind_t;

  typedef struct {
    row_kind_t         kind;
    reg_idx_t          idx;
    logic [RATE_W-1:0] rate;
    in_word_t          w;
    bit                typed;
    out_word_t         want;
  } row_t;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // block ports
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        src_valid = 1'b0;
  logic        src_ready;
  in_word_t    src_word = '0;
  logic        res_valid;
  logic        res_ready = 1'b0;
  out_word_t   res_word;

  linear_interp_resampler_core DUT (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .src_valid(src_valid), .src_ready(src_ready), .src_word(src_word),
    .res_valid(res_valid), .res_ready(res_ready), .res_word(res_word)
  );

  // predictor copy of rates and stream state
  logic [RATE_W-1:0]   src_hz = SRC_RATE_RST;
  logic [RATE_W-1:0]   dst_hz = DST_RATE_RST;
  logic signed [15:0]  last_in = '0;
  bit                  have_last = 1'b0;
  bit [31:0]           word_count = '0;
  bit [31:0]           pos_whole = '0;
  bit [RATE_W-1:0]     pos_frac = '0;

  out_word_t step_res[$];
  out_word_t pending_out[$];
  row_t      dir_tab[$];

  int mismatch_cnt = 0;
  int cycle_cnt = 0;
  int gap_pct = 25;
  int stall_pct = 25;
  int hold_cnt = 0;
  bit calm = 1'b0;
  logic signed [15:0] walk_base = '0;

  function automatic out_word_t res_of(logic signed [15:0] v, bit vld, bit re, bit se, bit er);
    out_word_t r;
    r.sample_out  = v;
    r.valid_res   = vld;
    r.run_end     = re;
    r.stream_end  = se;
    r.ratio_error = er;
    return r;
  endfunction

  function automatic void restart_stream();
    last_in = '0;
    have_last = 1'b0;
    word_count = '0;
    pos_whole = '0;
    pos_frac = '0;
  endfunction

  // move the output position one output further along the source
  function automatic void step_position();
    bit [RATE_W:0] rsum;
    pos_whole += 32'(src_hz / dst_hz);
    rsum = {1'b0, pos_frac} + 19'(src_hz % dst_hz);
    if (rsum >= 19'(dst_hz)) begin
      rsum -= 19'(dst_hz);
      pos_whole += 32'd1;
    end
    pos_frac = rsum[RATE_W-1:0];
  endfunction

  // results one source word causes, left in step_res
  function automatic void resample_step(in_word_t w);
    logic signed [15:0] s;
    bit fin;
    bit [31:0] prev_idx;
    longint num, den, q;
    s = w.sample_in;
    fin = w.final_in;
    step_res.delete();
    // unusable rate pair: word passes through flagged
    if (src_hz == 0 || dst_hz == 0 || int'(dst_hz) > MAX_UP * int'(src_hz)) begin
      step_res.push_back(res_of(s, 1'b1, 1'b1, fin, 1'b1));
      if (fin)
        restart_stream();
      return;
    end
    // fold a remainder left too large by a rate change
    if (pos_frac >= dst_hz) begin
      pos_whole += 32'(pos_frac / dst_hz);
      pos_frac = pos_frac % dst_hz;
    end
    // outputs between the previous word and this one
    if (have_last) begin
      prev_idx = word_count - 32'd1;
      while (step_res.size() < MAX_RUN && pos_whole == prev_idx) begin
        den = longint'(dst_hz);
        num = longint'(last_in) * (den - longint'(pos_frac)) + longint'(s) * longint'(pos_frac);
        q = num / den;
        if (num % den != 0 && num < 0)
          q = q - 1;
        step_res.push_back(res_of(16'(q), 1'b1, 1'b0, 1'b0, 1'b0));
        step_position();
      end
    end
    // last word of a stream repeats itself up to the end
    if (fin) begin
      while (step_res.size() < MAX_RUN && pos_whole == word_count) begin
        step_res.push_back(res_of(s, 1'b1, 1'b0, 1'b0, 1'b0));
        step_position();
      end
      if (step_res.size() == 0)
        step_res.push_back(res_of(16'sd0, 1'b0, 1'b0, 1'b0, 1'b0));
    end
    if (step_res.size() != 0) begin
      step_res[step_res.size()-1].run_end = 1'b1;
      if (fin)
        step_res[step_res.size()-1].stream_end = 1'b1;
    end
    last_in = s;
    have_last = 1'b1;
    word_count += 32'd1;
    if (fin)
      restart_stream();
  endfunction

  function automatic logic [RATE_W-1:0] pick_rate();
    case ($urandom_range(15))
      0: return 18'd8000;
      1: return 18'd11025;
      2: return 18'd16000;
      3: return 18'd22050;
      4: return 18'd32000;
      5: return 18'd44100;
      6: return 18'd48000;
      7: return 18'd96000;
      8: return 18'd1000;
      9: return 18'd192000;
      10: return 18'($urandom_range(0, 262143));
      default: return 18'($urandom_range(1000, 192000));
    endcase
  endfunction

  function automatic logic signed [15:0] draw_sample();
    case ($urandom_range(4))
      0, 1: return 16'($urandom);
      2: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      3: return walk_base + 16'($urandom_range(0, 511)) - 16'sd256;
      default: return $urandom_range(1) ? 16'sd0 : -16'sd1;
    endcase
  endfunction

  task automatic tab_cfg(reg_idx_t idx, logic [RATE_W-1:0] rate);
    row_t r;
    r.kind = ROW_CFG;
    r.idx = idx;
    r.rate = rate;
    r.w = '0;
    r.typed = 1'b0;
    r.want = '0;
    dir_tab.push_back(r);
  endtask

  task automatic tab_word(logic signed [15:0] s, bit fin, bit typed = 1'b0,
                          out_word_t want = '0);
    row_t r;
    r.kind = ROW_WORD;
    r.idx = REG_SRC_RATE;
    r.rate = '0;
    r.w.sample_in = s;
    r.w.final_in = fin;
    r.typed = typed;
    r.want = want;
    dir_tab.push_back(r);
  endtask

  // apb register write: setup then access
  task automatic write_rate(reg_idx_t idx, logic [RATE_W-1:0] rate);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= 32'(rate);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready)
      @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_SRC_RATE)
      src_hz = rate;
    else
      dst_hz = rate;
    @(posedge clk);
  endtask

  task automatic idle_src(int n);
    src_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // hold off the source until every expected word is back and the block is quiet
  task automatic settle();
    src_valid <= 1'b0;
    @(posedge clk);
    while (pending_out.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // send one word, predict its results, maybe leave a gap
  task automatic push_word(in_word_t w, bit typed = 1'b0, out_word_t want = '0);
    src_valid <= 1'b1;
    src_word <= w;
    @(posedge clk);
    while (!src_ready)
      @(posedge clk);
    resample_step(w);
    walk_base = w.sample_in;
    if (typed)
      pending_out.push_back(want);
    else
      foreach (step_res[i])
        pending_out.push_back(step_res[i]);
    if (!calm && $urandom_range(99) < gap_pct)
      idle_src($urandom_range(1, 13));
  endtask

  // result side back-pressure in bursts
  always @(posedge clk) begin
    if (calm || stall_pct == 0) begin
      res_ready <= 1'b1;
    end else if (hold_cnt != 0) begin
      hold_cnt = hold_cnt - 1;
      res_ready <= 1'b0;
    end else if ($urandom_range(99) < stall_pct) begin
      hold_cnt = $urandom_range(0, 12);
      res_ready <= 1'b0;
    end else begin
      res_ready <= 1'b1;
    end
  end

  // compare each result word with the oldest expectation
  always @(posedge clk) begin
    out_word_t exp_w;
    if (!rst && res_valid && res_ready) begin
      if (pending_out.size() == 0) begin
        mismatch_cnt++;
        $display("%0t: unexpected word, expected none", $time);
        $display("%0t:   got sample %0d valid %0b run_end %0b stream_end %0b error %0b",
                 $time, res_word.sample_out, res_word.valid_res, res_word.run_end,
                 res_word.stream_end, res_word.ratio_error);
      end else begin
        exp_w = pending_out.pop_front();
        if (res_word.sample_out !== exp_w.sample_out ||
            res_word.valid_res !== exp_w.valid_res ||
            res_word.run_end !== exp_w.run_end || res_word.stream_end !== exp_w.stream_end ||
            res_word.ratio_error !== exp_w.ratio_error) begin
          mismatch_cnt++;
          $display("%0t: mismatch, expected sample %0d valid %0b run_end %0b",
                   $time, exp_w.sample_out, exp_w.valid_res, exp_w.run_end);
          $display("%0t:   expected stream_end %0b error %0b",
                   $time, exp_w.stream_end, exp_w.ratio_error);
          $display("%0t:   got sample %0d valid %0b run_end %0b stream_end %0b error %0b",
                   $time, res_word.sample_out, res_word.valid_res, res_word.run_end,
                   res_word.stream_end, res_word.ratio_error);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // stimulus
  initial begin
    int items_sent;
    int phase_len;
    int stream_left;
    logic [RATE_W-1:0] s_new, d_new, tmp;
    in_word_t w;

    // lone final word at reset rates is its own output
    tab_word(16'sd1234, 1'b1, 1'b1, res_of(16'sd1234, 1'b1, 1'b1, 1'b1, 1'b0));
    tab_word(-16'sd32768, 1'b0);
    tab_word(16'sd32767, 1'b0);
    tab_word(-16'sd32768, 1'b0);
    tab_word(16'sd32767, 1'b0);
    tab_word(-16'sd1, 1'b1);
    // largest allowed upsampling, longest runs
    tab_cfg(REG_SRC_RATE, 18'd1000);
    tab_cfg(REG_DST_RATE, 18'd16000);
    tab_word(16'sd32767, 1'b0);
    tab_word(-16'sd32768, 1'b0);
    tab_word(16'sd32767, 1'b1);
    // one past the upsampling limit
    tab_cfg(REG_DST_RATE, 18'd16001);
    tab_word(-16'sd32768, 1'b0, 1'b1, res_of(-16'sd32768, 1'b1, 1'b1, 1'b0, 1'b1));
    tab_word(16'sd32767, 1'b1, 1'b1, res_of(16'sd32767, 1'b1, 1'b1, 1'b1, 1'b1));
    // heavy downsampling, final run with no output
    tab_cfg(REG_SRC_RATE, 18'd192000);
    tab_cfg(REG_DST_RATE, 18'd1000);
    tab_word(16'sd100, 1'b0);
    tab_word(-16'sd200, 1'b0);
    tab_word(16'sd300, 1'b1, 1'b1, res_of(16'sd0, 1'b0, 1'b1, 1'b1, 1'b0));
    // zero rates
    tab_cfg(REG_SRC_RATE, 18'd0);
    tab_word(16'sd5, 1'b0, 1'b1, res_of(16'sd5, 1'b1, 1'b1, 1'b0, 1'b1));
    tab_cfg(REG_SRC_RATE, 18'd1000);
    tab_cfg(REG_DST_RATE, 18'd0);
    tab_word(-16'sd5, 1'b1, 1'b1, res_of(-16'sd5, 1'b1, 1'b1, 1'b1, 1'b1));
    // full-scale register values
    tab_cfg(REG_SRC_RATE, 18'd262143);
    tab_cfg(REG_DST_RATE, 18'd262143);
    tab_word(16'sd7, 1'b0);
    tab_word(-16'sd7, 1'b1);
    // rate change mid-stream leaves the remainder past the new dst rate
    tab_cfg(REG_SRC_RATE, 18'd100000);
    tab_cfg(REG_DST_RATE, 18'd150000);
    tab_word(16'sd7, 1'b0);
    tab_word(-16'sd7, 1'b0);
    tab_word(16'sd8, 1'b0);
    tab_word(16'sd9, 1'b0);
    tab_cfg(REG_DST_RATE, 18'd20000);
    tab_word(16'sd10, 1'b0);
    tab_word(16'sd11, 1'b0);
    tab_word(16'sd12, 1'b1);

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part
    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        settle();
        write_rate(dir_tab[i].idx, dir_tab[i].rate);
      end else begin
        push_word(dir_tab[i].w, dir_tab[i].typed, dir_tab[i].want);
      end
    end

    // random phases: new rates, then streams that may run across the next change
    items_sent = 0;
    stream_left = 0;
    while (items_sent < RAND_ITEMS) begin
      settle();
      s_new = pick_rate();
      d_new = pick_rate();
      if (int'(d_new) > MAX_UP * int'(s_new) && $urandom_range(3) != 0) begin
        tmp = s_new;
        s_new = d_new;
        d_new = tmp;
      end
      if ($urandom_range(5) != 0)
        write_rate(REG_SRC_RATE, s_new);
      write_rate(REG_DST_RATE, d_new);
      case ($urandom_range(3))
        0: gap_pct = 0;
        1: gap_pct = 10;
        2: gap_pct = 35;
        default: gap_pct = 70;
      endcase
      case ($urandom_range(3))
        0: stall_pct = 0;
        1: stall_pct = 10;
        2: stall_pct = 35;
        default: stall_pct = 70;
      endcase
      phase_len = $urandom_range(15, 45);
      // the last phase takes every remaining word so the quiet tail has no pause
      if (RAND_ITEMS - items_sent - phase_len < CALM_ITEMS)
        phase_len = RAND_ITEMS - items_sent;
      for (int k = 0; k < phase_len && items_sent < RAND_ITEMS; k++) begin
        // quiet tail with no idling on either side
        if (items_sent >= RAND_ITEMS - CALM_ITEMS)
          calm = 1'b1;
        if (stream_left == 0)
          stream_left = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 30);
        stream_left--;
        w.sample_in = draw_sample();
        w.final_in = (stream_left == 0);
        // now and then a stream is cut short
        if ($urandom_range(24) == 0) begin
          w.final_in = 1'b1;
          stream_left = 0;
        end
        push_word(w);
        items_sent++;
      end
    end

    settle();
    if (mismatch_cnt == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
